### rtl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants for the signed varint codec.
// ----------------------------------------------------------------------------
package svc_pkg;

	localparam int VALUE_BITS_DEF = 32;
	// encoder works on a 35-bit image; 6 head bits + 4 groups of 7 fill 34 bits of it
	localparam int ENC_BITS       = 35;
	localparam int GRP_BITS       = 7;
	localparam int HEAD_BITS      = 6;
	localparam int MAX_GROUPS     = 4;

	localparam logic [1:0] HEAD_TAG = 2'b01;
	localparam logic       CONT_TAG = 1'b1;

	typedef enum logic [1:0] {
		KIND_DECODE = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic {
		OUT_BYTE  = 1'b0,
		OUT_VALUE = 1'b1
	} out_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIZE,
		ST_EMIT
	} state_t;

endpackage

### rtl/signed_varint_codec.sv
// Decode and flush items finish in the accept cycle; a result is in the
// output register on the next cycle. Encode of a value needing k continuation
// bytes runs as: load, k shifts of the sizing shifter (7 bits per shift), head
// byte, k continuation bytes, one byte per cycle out while the output is not stalled.
// The block takes one item at a time; output stalls delay the head and continuation bytes.
// Reset clears the accumulator, the pending flag and the output valid flag.
// ----------------------------------------------------------------------------
// signed_varint_codec
// Encoder/decoder for head byte 01sddddd plus continuation bytes 1ddddddd.
// ----------------------------------------------------------------------------
module signed_varint_codec #(
	parameter int VALUE_BITS = svc_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // byte_in[7:0], value_in[39:8]
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // out_byte[7:0], out_value[39:8]
	output logic        m_axis_tuser,   // out_kind
	output logic        m_axis_tlast
);

	import svc_pkg::*;

	state_t                        state_q, state_nxt;
	logic signed [VALUE_BITS-1:0]  acc_q;
	logic                          pending_q;
	logic signed [ENC_BITS-1:0]    t_q;
	logic [MAX_GROUPS*GRP_BITS-1:0] v_q;
	logic [2:0]                    k_q;
	logic [1:0]                    i_q;

	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic signed [31:0]            out_value_q;
	logic                          out_kind_q;
	logic                          out_last_q;

	kind_t                         kind;
	logic [7:0]                    byte_in;
	logic signed [31:0]            value_in;
	logic signed [VALUE_BITS-1:0]  v_wrap;
	logic signed [ENC_BITS-1:0]    v_enc;
	logic                          accept;
	logic                          slot_free;
	logic                          fits;
	logic [GRP_BITS-1:0]           grp;

	logic                          emit;
	logic [7:0]                    emit_byte;
	logic signed [31:0]            emit_value;
	out_kind_t                     emit_kind;
	logic                          emit_last;

	assign kind     = kind_t'(s_axis_tuser);
	assign byte_in  = s_axis_tdata[7:0];
	assign value_in = s_axis_tdata[39:8];
	assign v_wrap   = VALUE_BITS'(value_in);
	assign v_enc    = ENC_BITS'(v_wrap);

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// value fits once everything above the head field is sign
	assign fits = (&t_q[ENC_BITS-1:HEAD_BITS-1]) || !(|t_q[ENC_BITS-1:HEAD_BITS-1]);

	always_comb begin
		case (i_q)
			2'd0:    grp = v_q[GRP_BITS-1:0];
			2'd1:    grp = v_q[2*GRP_BITS-1:GRP_BITS];
			2'd2:    grp = v_q[3*GRP_BITS-1:2*GRP_BITS];
			default: grp = v_q[4*GRP_BITS-1:3*GRP_BITS];
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_ENCODE)
					state_nxt = ST_SIZE;
			end
			ST_SIZE: begin
				if (fits && slot_free)
					state_nxt = (k_q == 3'd0) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && i_q == 2'd0)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// result generation
	always_comb begin
		emit       = 1'b0;
		emit_byte  = '0;
		emit_value = '0;
		emit_kind  = OUT_BYTE;
		emit_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && pending_q &&
				    ((kind == KIND_DECODE && !byte_in[7]) || kind == KIND_FLUSH)) begin
					emit       = 1'b1;
					emit_kind  = OUT_VALUE;
					emit_value = 32'(acc_q);
					emit_last  = 1'b1;
				end
			end
			ST_SIZE: begin
				if (fits && slot_free) begin
					emit      = 1'b1;
					emit_byte = {HEAD_TAG, t_q[HEAD_BITS-1:0]};
					emit_last = (k_q == 3'd0);
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = {CONT_TAG, grp};
					emit_last = (i_q == 2'd0);
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (accept) begin
				case (kind)
					KIND_DECODE: begin
						if (!byte_in[7]) begin
							acc_q     <= VALUE_BITS'($signed(byte_in[HEAD_BITS-1:0]));
							pending_q <= 1'b1;
						end else if (pending_q) begin
							acc_q <= {acc_q[VALUE_BITS-GRP_BITS-1:0], byte_in[GRP_BITS-1:0]};
						end
					end
					KIND_FLUSH: begin
						acc_q     <= '0;
						pending_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// sizing shifter and group sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			i_q <= '0;
		end else begin
			if (accept && kind == KIND_ENCODE) begin
				k_q <= '0;
			end else if (state_q == ST_SIZE) begin
				if (!fits)
					k_q <= k_q + 3'd1;
				else if (slot_free)
					i_q <= 2'(k_q - 3'd1);
			end else if (state_q == ST_EMIT && slot_free) begin
				i_q <= i_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_ENCODE) begin
			t_q <= v_enc;
			v_q <= v_enc[MAX_GROUPS*GRP_BITS-1:0];
		end else if (state_q == ST_SIZE && !fits) begin
			t_q <= t_q >>> GRP_BITS;
		end
		if (emit) begin
			out_byte_q  <= emit_byte;
			out_value_q <= emit_value;
			out_kind_q  <= emit_kind;
			out_last_q  <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_value_q, out_byte_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIZE |-> k_q <= 3'd4)
		else $error("group count out of range");

	a_enc_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_ENCODE |=> state_q == ST_SIZE)
		else $error("encode item did not start sizing");

	a_value_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == OUT_VALUE |-> m_axis_tlast)
		else $error("decoded value not marked last");

	a_byte_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == OUT_BYTE |-> m_axis_tdata[7] || m_axis_tdata[6])
		else $error("encoded byte lacks tag");
`endif

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_varint_codec. A short table of directed items
// (extremes, stray bytes, unused kind, flush cases) runs first, then random
// encode values and well-formed decode runs mixed with noise. Both stream
// sides idle in random bursts. Results are checked against a predictor of the
// codec that runs in step with the accepted input items, or a row's typed result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import svc_pkg::*;

	localparam int RAND_ITEMS  = 275;
	localparam int CALM_ITEMS  = 50;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		out_kind_t   okind;
		logic [7:0]  obyte;
		logic [31:0] oval;
		logic        olast;
	} codec_result_t;

	// nexp: -1 take the predictor, 0 no result, 1 the typed result
	typedef struct packed {
		kind_t         kind;
		logic [7:0]    byte_in;
		logic [31:0]   value_in;
		int            nexp;
		codec_result_t res;
	} stim_row_t;

	localparam codec_result_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;     // byte_in[7:0], value_in[39:8]
	logic [1:0]  s_tuser = '0;     // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // out_byte[7:0], out_value[39:8]
	logic        m_tuser;          // out_kind
	logic        m_tlast;

	codec_result_t out_expected[$];
	logic [31:0]   dec_acc = '0;
	bit            dec_busy = 1'b0;
	bit            calm = 1'b0;
	bit            hold_rx = 1'b0;
	int            fail_count = 0;
	int            cycle_count = 0;

	signed_varint_codec dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void codec_predict(input kind_t k, input logic [7:0] b,
			input logic [31:0] v, output codec_result_t res[$]);
		logic signed [63:0] wide;
		logic signed [63:0] top;
		logic [63:0]        grp;
		int                 ngrp;
		res = {};
		case (k)
			KIND_DECODE: begin
				if (!b[7]) begin
					if (dec_busy)
						res.push_back('{OUT_VALUE, 8'h00, dec_acc, 1'b1});
					dec_acc  = {{26{b[5]}}, b[5:0]};
					dec_busy = 1'b1;
				end else if (dec_busy) begin
					dec_acc = {dec_acc[24:0], b[6:0]};
				end
			end
			KIND_ENCODE: begin
				wide = {{32{v[31]}}, v};
				ngrp = 0;
				top  = wide >>> (HEAD_BITS - 1);
				while (ngrp < MAX_GROUPS && top != 0 && top != -1) begin
					ngrp++;
					top = wide >>> (HEAD_BITS - 1 + GRP_BITS * ngrp);
				end
				grp = wide >> (GRP_BITS * ngrp);
				res.push_back('{OUT_BYTE, {HEAD_TAG, grp[5:0]}, 32'h0, ngrp == 0});
				for (int i = ngrp - 1; i >= 0; i--) begin
					grp = wide >> (GRP_BITS * i);
					res.push_back('{OUT_BYTE, {CONT_TAG, grp[6:0]}, 32'h0, i == 0});
				end
			end
			KIND_FLUSH: begin
				if (dec_busy)
					res.push_back('{OUT_VALUE, 8'h00, dec_acc, 1'b1});
				dec_acc  = '0;
				dec_busy = 1'b0;
			end
			default: ;
		endcase
	endfunction

	task automatic drive_item(input kind_t k, input logic [7:0] b, input logic [31:0] v,
			input int nexp, input codec_result_t fixed);
		codec_result_t res[$];
		if (!calm && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {v, b};
		do @(posedge clk); while (!s_tready);
		codec_predict(k, b, v, res);
		if (nexp < 0)
			foreach (res[i]) out_expected.push_back(res[i]);
		else if (nexp == 1)
			out_expected.push_back(fixed);
	endtask

	// result side: checking, random back-pressure and one long hold-off
	initial begin : sink
		int            idle_left;
		int            hold_left;
		bit            hold_done;
		codec_result_t got;
		codec_result_t want;
		idle_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{out_kind_t'(m_tuser), m_tdata[7:0], m_tdata[39:8], m_tlast};
				if (out_expected.size() == 0) begin
					$error("unexpected result item: kind %0d byte %h value %h last %0d",
						got.okind, got.obyte, got.oval, got.olast);
					fail_count++;
				end else begin
					want = out_expected.pop_front();
					if (got.okind != want.okind) begin
						$error("out_kind: expected %0d, got %0d", want.okind, got.okind);
						fail_count++;
					end
					if (got.obyte != want.obyte) begin
						$error("out_byte: expected %h, got %h", want.obyte, got.obyte);
						fail_count++;
					end
					if (got.oval != want.oval) begin
						$error("out_value: expected %h, got %h", want.oval, got.oval);
						fail_count++;
					end
					if (got.olast != want.olast) begin
						$error("last: expected %0d, got %0d", want.olast, got.olast);
						fail_count++;
					end
				end
			end
			if (hold_rx && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				idle_left = $urandom_range(1, 13) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : source
		stim_row_t   directed [25];
		int          done_items;
		int          sel;
		int          width;
		int          nconts;
		bit          drained;
		kind_t       k;
		logic [7:0]  b;
		logic [31:0] v;
		directed = '{
			'{KIND_FLUSH,  8'h00, 32'h0000_0000,  0, NO_RES},   // nothing pending
			'{KIND_DECODE, 8'h80, 32'hFFFF_FFFF,  0, NO_RES},   // stray continuation
			'{KIND_NONE,   8'hFF, 32'h1234_5678,  0, NO_RES},
			'{KIND_ENCODE, 8'h00, 32'h0000_0000,  1, '{OUT_BYTE, 8'h40, 32'h0, 1'b1}},
			'{KIND_ENCODE, 8'hFF, 32'hFFFF_FFFF,  1, '{OUT_BYTE, 8'h7F, 32'h0, 1'b1}},
			'{KIND_ENCODE, 8'h00, 32'h0000_001F,  1, '{OUT_BYTE, 8'h5F, 32'h0, 1'b1}},
			'{KIND_ENCODE, 8'h00, 32'hFFFF_FFE0,  1, '{OUT_BYTE, 8'h60, 32'h0, 1'b1}},
			'{KIND_ENCODE, 8'h00, 32'h0000_0020, -1, NO_RES},
			'{KIND_ENCODE, 8'h00, 32'h7FFF_FFFF, -1, NO_RES},
			'{KIND_ENCODE, 8'h00, 32'h8000_0000, -1, NO_RES},
			'{KIND_ENCODE, 8'h5A, 32'hAAAA_5555, -1, NO_RES},
			'{KIND_DECODE, 8'h3F, 32'h0000_0000,  0, NO_RES},   // head with bit 6 clear
			'{KIND_DECODE, 8'hFF, 32'h0000_0000, -1, NO_RES},
			'{KIND_DECODE, 8'hFF, 32'h0000_0000, -1, NO_RES},
			'{KIND_DECODE, 8'hFF, 32'h0000_0000, -1, NO_RES},
			'{KIND_DECODE, 8'hFF, 32'h0000_0000, -1, NO_RES},
			'{KIND_DECODE, 8'hFF, 32'h0000_0000, -1, NO_RES},   // wraps past 32 bits
			'{KIND_NONE,   8'h00, 32'h0000_0000,  0, NO_RES},   // pending value kept
			'{KIND_DECODE, 8'h60, 32'h0000_0000, -1, NO_RES},
			'{KIND_FLUSH,  8'h00, 32'h0000_0000,  1, '{OUT_VALUE, 8'h00, 32'hFFFF_FFE0, 1'b1}},
			'{KIND_FLUSH,  8'h00, 32'h0000_0000,  0, NO_RES},
			'{KIND_DECODE, 8'h41, 32'h0000_0000,  0, NO_RES},
			'{KIND_FLUSH,  8'h00, 32'h0000_0000,  1, '{OUT_VALUE, 8'h00, 32'h0000_0001, 1'b1}},
			'{KIND_DECODE, 8'h7F, 32'h0000_0000,  0, NO_RES},
			'{KIND_FLUSH,  8'h00, 32'h0000_0000,  1, '{OUT_VALUE, 8'h00, 32'hFFFF_FFFF, 1'b1}}
		};
		done_items = 0;
		drained = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			drive_item(directed[i].kind, directed[i].byte_in, directed[i].value_in,
				directed[i].nexp, directed[i].res);

		while (done_items < RAND_ITEMS) begin
			calm = done_items >= RAND_ITEMS - CALM_ITEMS;
			if (done_items >= 100)
				hold_rx = 1'b1;
			if (done_items >= 180 && !drained) begin
				drained = 1'b1;
				s_tvalid <= 1'b0;
				while (out_expected.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				width = $urandom_range(1, 32);
				v = $signed($urandom << (32 - width)) >>> (32 - width);
				drive_item(KIND_ENCODE, 8'($urandom), v, -1, NO_RES);
				done_items++;
			end else if (sel < 80) begin
				b = {1'b0, $urandom_range(0, 7) != 0, 6'($urandom)};
				drive_item(KIND_DECODE, b, $urandom, -1, NO_RES);
				done_items++;
				nconts = $urandom_range(0, 5);
				repeat (nconts) begin
					drive_item(KIND_DECODE, {1'b1, 7'($urandom)}, $urandom, -1, NO_RES);
					done_items++;
				end
				if ($urandom_range(0, 3) == 0) begin
					drive_item(KIND_FLUSH, 8'($urandom), $urandom, -1, NO_RES);
					done_items++;
				end
			end else if (sel < 88) begin
				if (dec_busy)
					done_items++;
				drive_item(KIND_FLUSH, 8'($urandom), $urandom, -1, NO_RES);
			end else begin
				k = kind_t'($urandom_range(0, 3));
				b = 8'($urandom);
				if (k == KIND_ENCODE || (k == KIND_DECODE && (!b[7] || dec_busy))
						|| (k == KIND_FLUSH && dec_busy))
					done_items++;
				drive_item(k, b, $urandom, -1, NO_RES);
			end
		end

		s_tvalid <= 1'b0;
		while (out_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
